// ----- src/cbs_pkg.sv -----
`timescale 1ns / 1ps
// cbs_pkg: shared types, register indexes and defaults for the codebook background subtractor
// no dependencies
package cbs_pkg;

    localparam int DEF_MAX_PIXELS    = 524288;
    localparam int DEF_MAX_CODEWORDS = 8;
    localparam int DEF_TIME_BITS     = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_FRAMES    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PERIOD    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_CR        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_CB        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LOW      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_HIGH     = 4'd7;

    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd100;
    localparam logic [7:0]  RST_LEARN_FRAMES    = 8'd30;
    localparam logic [15:0] RST_CLEAR_PERIOD    = 16'd60;
    localparam logic [7:0]  RST_BOUND_Y         = 8'd10;
    localparam logic [7:0]  RST_BOUND_CR        = 8'd5;
    localparam logic [7:0]  RST_BOUND_CB        = 8'd5;
    localparam logic [8:0]  RST_MARGIN_LOW      = 9'd20;
    localparam logic [8:0]  RST_MARGIN_HIGH     = 9'd20;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cr;
        logic [7:0] cb;
        logic       end_of_frame;
    } t_pix_in;

    typedef struct packed {
        logic foreground;
        logic learning;
        logic codebook_full;
        logic frame_end;
    } t_pix_out;

    // commands from the sequencer, at most one per cycle
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic meta;
        logic rd;
        logic lex;
        logic lfin;
        logic cex;
        logic cfin;
        logic tex;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic learn_en;
        logic clear_en;
        logic test_en;
    } t_sts;

endpackage

// ----- src/cbs_ctrl.sv -----
`timescale 1ns / 1ps
// cbs_ctrl: sequencer for one pixel at a time and the post-reset clearing pass
// depends on cbs_pkg
module cbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cbs_pkg::t_sts i_sts,
    output cbs_pkg::t_cmd o_cmd
);
    import cbs_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_META, S_L_RD, S_L_EX, S_L_FIN,
        S_C_RD, S_C_EX, S_C_FIN, S_T_RD, S_T_EX, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_CLR: begin
                n_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.accept = 1'b1;
                    n_state      = S_META;
                end
            end
            S_META: begin
                n_cmd.meta = 1'b1;
                if (i_sts.learn_en)      n_state = S_L_RD;
                else if (i_sts.clear_en) n_state = S_C_RD;
                else if (i_sts.test_en)  n_state = S_T_RD;
                else                     n_state = S_DONE;
            end
            S_L_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_L_FIN;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state  = S_L_EX;
                end
            end
            S_L_EX: begin
                n_cmd.lex = 1'b1;
                n_state   = S_L_RD;
            end
            S_L_FIN: begin
                n_cmd.lfin = 1'b1;
                if (i_sts.clear_en)     n_state = S_C_RD;
                else if (i_sts.test_en) n_state = S_T_RD;
                else                    n_state = S_DONE;
            end
            S_C_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_C_FIN;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state  = S_C_EX;
                end
            end
            S_C_EX: begin
                n_cmd.cex = 1'b1;
                n_state   = S_C_RD;
            end
            S_C_FIN: begin
                n_cmd.cfin = 1'b1;
                n_state    = S_T_RD;
            end
            S_T_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state  = S_T_EX;
                end
            end
            S_T_EX: begin
                n_cmd.tex = 1'b1;
                n_state   = S_T_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_cmd.out_load)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd       = n_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(n_cmd)) else $error("more than one datapath command");
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready) else $error("pixel taken during clear pass");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");
    a_accept_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.accept |=> (r_state == S_META)) else $error("accept not followed by meta read");

endmodule

// ----- src/cbs_datapath.sv -----
`timescale 1ns / 1ps
// cbs_datapath: config registers, frame counters, per-pixel and codeword memories, codeword logic
// depends on cbs_pkg
module cbs_datapath #(
    parameter int MAX_PIXELS    = cbs_pkg::DEF_MAX_PIXELS,
    parameter int MAX_CODEWORDS = cbs_pkg::DEF_MAX_CODEWORDS,
    parameter int TIME_BITS     = cbs_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cbs_pkg::t_pix_in               i_pix,
    input  logic                           i_cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  cbs_pkg::t_cmd                  i_cmd,
    output cbs_pkg::t_sts                  o_sts,
    output cbs_pkg::t_pix_out              o_out
);
    import cbs_pkg::*;

    localparam int PX_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W    = $clog2(MAX_CODEWORDS + 1);
    localparam int IW       = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
    localparam int CW_DEPTH = MAX_PIXELS * (2 ** IW);
    localparam int AW       = PX_W + IW;

    // configuration
    logic [15:0]       r_update_interval, r_clear_period;
    logic [7:0]        r_learn_frames;
    logic [2:0][7:0]   r_bound;
    logic signed [8:0] r_margin_low, r_margin_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_interval <= RST_UPDATE_INTERVAL;
            r_learn_frames    <= RST_LEARN_FRAMES;
            r_clear_period    <= RST_CLEAR_PERIOD;
            r_bound           <= {RST_BOUND_CB, RST_BOUND_CR, RST_BOUND_Y};
            r_margin_low      <= RST_MARGIN_LOW;
            r_margin_high     <= RST_MARGIN_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UPDATE_INTERVAL: r_update_interval <= i_cfg_data;
                CFG_LEARN_FRAMES:    r_learn_frames    <= i_cfg_data[7:0];
                CFG_CLEAR_PERIOD:    r_clear_period    <= i_cfg_data;
                CFG_BOUND_Y:         r_bound[0]        <= i_cfg_data[7:0];
                CFG_BOUND_CR:        r_bound[1]        <= i_cfg_data[7:0];
                CFG_BOUND_CB:        r_bound[2]        <= i_cfg_data[7:0];
                CFG_MARGIN_LOW:      r_margin_low      <= i_cfg_data[8:0];
                CFG_MARGIN_HIGH:     r_margin_high     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // frame bookkeeping
    logic [31:0]     r_frame_count;
    logic [PX_W-1:0] r_pos;
    logic [15:0]     r_up_phase, r_clr_phase;
    logic [15:0]     ui_eff, cp_eff;
    logic [16:0]     up_inc, clr_inc;
    logic [PX_W:0]   pos_inc;
    logic            n_learning, n_up_due, n_clr_due;

    assign ui_eff     = (r_update_interval == '0) ? 16'd1 : r_update_interval;
    assign cp_eff     = (r_clear_period == '0) ? 16'd1 : r_clear_period;
    assign up_inc     = {1'b0, r_up_phase} + 17'd1;
    assign clr_inc    = {1'b0, r_clr_phase} + 17'd1;
    assign pos_inc    = {1'b0, r_pos} + {{PX_W{1'b0}}, 1'b1};
    assign n_learning = ({1'b0, r_frame_count} + 33'd1) < {25'd0, r_learn_frames};
    assign n_up_due   = r_up_phase >= (ui_eff - 16'd1);
    assign n_clr_due  = r_clr_phase >= (cp_eff - 16'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_pos         <= '0;
            r_up_phase    <= '0;
            r_clr_phase   <= '0;
        end else if (i_cmd.accept) begin
            if (i_pix.end_of_frame) begin
                if (r_frame_count != '1) r_frame_count <= r_frame_count + 32'd1;
                r_up_phase  <= (up_inc >= {1'b0, ui_eff}) ? 16'd0 : up_inc[15:0];
                r_clr_phase <= (clr_inc >= {1'b0, cp_eff}) ? 16'd0 : clr_inc[15:0];
                r_pos       <= '0;
            end else begin
                r_pos <= (pos_inc >= (PX_W+1)'(MAX_PIXELS)) ? '0 : pos_inc[PX_W-1:0];
            end
        end
    end

    // item registers
    logic [2:0][7:0]       r_p;
    logic [PX_W-1:0]       r_px;
    logic                  r_eof, r_learning, r_learn_en, r_clear_en;
    logic [CNT_W-1:0]      r_n, r_idx, r_k;
    logic [TIME_BITS-1:0]  r_t;
    logic                  r_found, r_full, r_fit;

    // per-pixel store
    logic [CNT_W-1:0]     r_meta_cnt  [MAX_PIXELS];
    logic [TIME_BITS-1:0] r_meta_time [MAX_PIXELS];
    logic [CNT_W-1:0]     r_meta_cnt_q;
    logic [TIME_BITS-1:0] r_meta_time_q;
    logic [PX_W-1:0]      r_clr_addr;
    logic                 meta_we;
    logic [PX_W-1:0]      meta_addr;
    logic [CNT_W-1:0]     meta_cnt_w;
    logic [TIME_BITS-1:0] meta_time_w;

    // codeword store
    logic [2:0][7:0]      r_cw_lo    [CW_DEPTH];
    logic [2:0][7:0]      r_cw_hi    [CW_DEPTH];
    logic [2:0][7:0]      r_cw_min   [CW_DEPTH];
    logic [2:0][7:0]      r_cw_max   [CW_DEPTH];
    logic [TIME_BITS-1:0] r_cw_last  [CW_DEPTH];
    logic [TIME_BITS-1:0] r_cw_stale [CW_DEPTH];
    logic [2:0][7:0]      q_lo, q_hi, q_min, q_max;
    logic [TIME_BITS-1:0] q_last, q_stale;

    logic                 cw_we;
    logic [AW-1:0]        cw_waddr;
    logic [2:0][7:0]      w_lo, w_hi, w_min, w_max;
    logic [TIME_BITS-1:0] w_last, w_stale;

    // learn targets
    logic [2:0][7:0] hi_t, lo_t;
    logic [2:0][8:0] sum_b;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_b[c] = {1'b0, r_p[c]} + {1'b0, r_bound[c]};
            hi_t[c]  = sum_b[c][8] ? 8'hFF : sum_b[c][7:0];
            lo_t[c]  = (r_p[c] > r_bound[c]) ? (r_p[c] - r_bound[c]) : 8'd0;
        end
    end

    // codeword evaluation
    logic                 match, take, keep, fits, can_insert;
    logic [2:0][7:0]      l_lo, l_hi, l_min, l_max;
    logic [TIME_BITS-1:0] l_last, l_run, l_stale, t_inc;
    logic signed [10:0]   lo_b, hi_b, v_s;
    logic [CNT_W-1:0]     n_after;

    always_comb begin
        match = 1'b1;
        fits  = 1'b1;
        l_lo  = q_lo;
        l_hi  = q_hi;
        l_min = q_min;
        l_max = q_max;
        lo_b  = '0;
        hi_b  = '0;
        v_s   = '0;
        for (int c = 0; c < 3; c++) begin
            if (!(q_lo[c] <= r_p[c] && r_p[c] <= q_hi[c])) match = 1'b0;
            v_s  = $signed({3'b000, r_p[c]});
            lo_b = $signed({3'b000, q_min[c]}) - 11'(r_margin_low);
            hi_b = $signed({3'b000, q_max[c]}) + 11'(r_margin_high);
            if (!(lo_b <= v_s && v_s <= hi_b)) fits = 1'b0;
        end
        take = match && !r_found;
        if (take) begin
            for (int c = 0; c < 3; c++) begin
                if (q_max[c] < r_p[c])      l_max[c] = r_p[c];
                else if (q_min[c] > r_p[c]) l_min[c] = r_p[c];
                if (q_hi[c] < hi_t[c]) l_hi[c] = q_hi[c] + 8'd1;
                if (q_lo[c] > lo_t[c]) l_lo[c] = q_lo[c] - 8'd1;
            end
        end
        l_last  = take ? r_t : q_last;
        l_run   = (r_t >= l_last) ? (r_t - l_last) : '0;
        l_stale = (q_stale < l_run) ? l_run : q_stale;
        keep    = q_stale <= (r_t >> 1);
        t_inc   = (r_meta_time_q == '1) ? r_meta_time_q : (r_meta_time_q + 1'b1);
        can_insert = !r_found && (r_n < CNT_W'(MAX_CODEWORDS));
        n_after    = can_insert ? (r_n + 1'b1) : r_n;
    end

    // store write selection
    always_comb begin
        cw_we    = 1'b0;
        cw_waddr = {r_px, r_idx[IW-1:0]};
        w_lo     = l_lo;
        w_hi     = l_hi;
        w_min    = l_min;
        w_max    = l_max;
        w_last   = l_last;
        w_stale  = l_stale;
        if (i_cmd.lex) begin
            cw_we = 1'b1;
        end else if (i_cmd.lfin) begin
            cw_we    = can_insert;
            cw_waddr = {r_px, r_n[IW-1:0]};
            w_lo     = lo_t;
            w_hi     = hi_t;
            w_min    = r_p;
            w_max    = r_p;
            w_last   = r_t;
            w_stale  = '0;
        end else if (i_cmd.cex) begin
            cw_we    = keep;
            cw_waddr = {r_px, r_k[IW-1:0]};
            w_lo     = q_lo;
            w_hi     = q_hi;
            w_min    = q_min;
            w_max    = q_max;
            w_last   = '0;
            w_stale  = q_stale;
        end

        meta_we     = 1'b0;
        meta_addr   = r_px;
        meta_cnt_w  = n_after;
        meta_time_w = r_t;
        if (i_cmd.clr_step) begin
            meta_we     = 1'b1;
            meta_addr   = r_clr_addr;
            meta_cnt_w  = '0;
            meta_time_w = '0;
        end else if (i_cmd.lfin) begin
            meta_we = 1'b1;
        end else if (i_cmd.cfin) begin
            meta_we     = 1'b1;
            meta_cnt_w  = r_k;
            meta_time_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_cnt[meta_addr]  <= meta_cnt_w;
            r_meta_time[meta_addr] <= meta_time_w;
        end
        if (i_cmd.accept) begin
            r_meta_cnt_q  <= r_meta_cnt[r_pos];
            r_meta_time_q <= r_meta_time[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw_we) begin
            r_cw_lo[cw_waddr]    <= w_lo;
            r_cw_hi[cw_waddr]    <= w_hi;
            r_cw_min[cw_waddr]   <= w_min;
            r_cw_max[cw_waddr]   <= w_max;
            r_cw_last[cw_waddr]  <= w_last;
            r_cw_stale[cw_waddr] <= w_stale;
        end
        if (i_cmd.rd) begin
            q_lo    <= r_cw_lo[{r_px, r_idx[IW-1:0]}];
            q_hi    <= r_cw_hi[{r_px, r_idx[IW-1:0]}];
            q_min   <= r_cw_min[{r_px, r_idx[IW-1:0]}];
            q_max   <= r_cw_max[{r_px, r_idx[IW-1:0]}];
            q_last  <= r_cw_last[{r_px, r_idx[IW-1:0]}];
            q_stale <= r_cw_stale[{r_px, r_idx[IW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p        <= {i_pix.cb, i_pix.cr, i_pix.y};
            r_eof      <= i_pix.end_of_frame;
            r_px       <= r_pos;
            r_learning <= n_learning;
            r_learn_en <= n_learning || n_up_due;
            r_clear_en <= !n_learning && n_clr_due;
            r_full     <= 1'b0;
        end
        if (i_cmd.meta) begin
            r_n     <= r_meta_cnt_q;
            r_t     <= r_learn_en ? t_inc : r_meta_time_q;
            r_idx   <= '0;
            r_k     <= '0;
            r_found <= 1'b0;
            r_fit   <= 1'b0;
        end
        if (i_cmd.lex) begin
            if (take) r_found <= 1'b1;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.lfin) begin
            r_full <= !r_found && !can_insert;
            r_n    <= n_after;
            r_idx  <= '0;
        end
        if (i_cmd.cex) begin
            if (keep) r_k <= r_k + 1'b1;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.cfin) begin
            r_n   <= r_k;
            r_t   <= '0;
            r_idx <= '0;
        end
        if (i_cmd.tex) begin
            if (fits) r_fit <= 1'b1;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_out.foreground    <= !r_learning && !r_fit;
            o_out.learning      <= r_learning;
            o_out.codebook_full <= r_full;
            o_out.frame_end     <= r_eof;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == PX_W'(MAX_PIXELS - 1));
    assign o_sts.walk_done = (r_idx >= r_n);
    assign o_sts.learn_en  = r_learn_en;
    assign o_sts.clear_en  = r_clear_en;
    assign o_sts.test_en   = !r_learning;

endmodule

// ----- src/codebook_background_subtraction.sv -----
`timescale 1ns / 1ps
// codebook_background_subtraction: top level, sequencer plus datapath
// depends on cbs_pkg, cbs_ctrl, cbs_datapath
//
// codebook background subtractor for a raster stream of YCrCb pixels with an end-of-frame
// mark; one result beat per pixel beat. after reset a clearing pass zeroes the per-pixel
// store, one pixel a cycle, and no pixel is taken until it is done (configuration writes
// are taken throughout). pixels are handled one at a time: each is accepted and its
// per-pixel entry read, then comes the learning walk during the learning frames or
// when an update is due and, outside the learning frames, the stale clearing walk when a
// clear is due and the foreground test; each walk reads and then evaluates one codeword
// at a time through the single read port of the codeword memory. the result sits in an
// output register so the next pixel beat is taken while it waits. the user must write
// configuration only while idle; the block itself does not enforce it.
module codebook_background_subtraction #(
    parameter int MAX_PIXELS    = cbs_pkg::DEF_MAX_PIXELS,
    parameter int MAX_CODEWORDS = cbs_pkg::DEF_MAX_CODEWORDS,
    parameter int TIME_BITS     = cbs_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cbs_pkg::t_pix_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cbs_pkg::t_pix_out              o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cbs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    cbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbs_datapath #(
        .MAX_PIXELS    (MAX_PIXELS),
        .MAX_CODEWORDS (MAX_CODEWORDS),
        .TIME_BITS     (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out_data)
    );

endmodule

// ----- sim/cbs_checker.sv -----
`timescale 1ns / 1ps
// cbs_checker: watches the pixel, result and register channels of the codebook subtractor,
// predicts each result beat and compares it field by field
// depends on cbs_pkg
module cbs_checker
    import cbs_pkg::*;
#(
    parameter int MAX_PIXELS    = DEF_MAX_PIXELS,
    parameter int MAX_CODEWORDS = DEF_MAX_CODEWORDS,
    parameter int TIME_BITS     = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_pix_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_pix_out              i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int NCW = MAX_PIXELS * MAX_CODEWORDS;
    localparam longint unsigned TMAX = (64'd1 << TIME_BITS) - 1;

    // register copy
    int unsigned upd_int, clr_per;
    int unsigned learn_lim;
    int          bnd[3];
    int          mlo, mhi;

    // stream state
    int unsigned frames, pos, upd_ph, clr_ph;
    int          cw_count[MAX_PIXELS];
    int unsigned px_time[MAX_PIXELS];

    // codeword stores
    bit [7:0]    box_lo[NCW][3];
    bit [7:0]    box_hi[NCW][3];
    bit [7:0]    rng_min[NCW][3];
    bit [7:0]    rng_max[NCW][3];
    int unsigned last_hit[NCW];
    int unsigned stale[NCW];

    t_pix_out    expected_q[$];

    function automatic int used_of(int px);
        return cw_count[px] > MAX_CODEWORDS ? MAX_CODEWORDS : cw_count[px];
    endfunction

    function automatic bit learn_cw(int px, int p[3]);
        int n, i, c, e, base;
        int hi[3], lo[3];
        longint unsigned t, run;
        bit ok, full;
        n = used_of(px);
        base = px * MAX_CODEWORDS;
        full = 0;
        t = px_time[px];
        if (t < TMAX) t++;
        px_time[px] = t;
        for (c = 0; c < 3; c++) begin
            hi[c] = p[c] + bnd[c] > 255 ? 255 : p[c] + bnd[c];
            lo[c] = p[c] > bnd[c] ? p[c] - bnd[c] : 0;
        end
        for (i = 0; i < n; i++) begin
            e = base + i;
            ok = 1;
            for (c = 0; c < 3; c++)
                if (!(box_lo[e][c] <= p[c] && p[c] <= box_hi[e][c])) ok = 0;
            if (ok) begin
                last_hit[e] = t;
                for (c = 0; c < 3; c++) begin
                    if (rng_max[e][c] < p[c]) rng_max[e][c] = p[c];
                    else if (rng_min[e][c] > p[c]) rng_min[e][c] = p[c];
                end
                break;
            end
        end
        for (c = 0; c < n; c++) begin
            e = base + c;
            run = t >= last_hit[e] ? t - last_hit[e] : 0;
            if (stale[e] < run) stale[e] = run;
        end
        if (i == n) begin
            if (n >= MAX_CODEWORDS) begin
                full = 1;
            end else begin
                e = base + n;
                for (c = 0; c < 3; c++) begin
                    box_hi[e][c] = hi[c];
                    box_lo[e][c] = lo[c];
                    rng_max[e][c] = p[c];
                    rng_min[e][c] = p[c];
                end
                last_hit[e] = t;
                stale[e] = 0;
                cw_count[px] = n + 1;
            end
        end
        if (!full) begin
            // matched or new codeword creeps one step towards the pixel's box
            e = base + i;
            for (c = 0; c < 3; c++) begin
                if (box_hi[e][c] < hi[c]) box_hi[e][c]++;
                if (box_lo[e][c] > lo[c]) box_lo[e][c]--;
            end
        end
        return full;
    endfunction

    function automatic void clear_cw(int px);
        int n, i, k, s, d, base;
        int unsigned thr;
        n = used_of(px);
        base = px * MAX_CODEWORDS;
        thr = px_time[px] >> 1;
        k = 0;
        for (i = 0; i < n; i++) begin
            s = base + i;
            if (stale[s] > thr) continue;
            if (k != i) begin
                d = base + k;
                box_lo[d] = box_lo[s];
                box_hi[d] = box_hi[s];
                rng_min[d] = rng_min[s];
                rng_max[d] = rng_max[s];
                stale[d] = stale[s];
            end
            last_hit[base + k] = 0;
            k++;
        end
        cw_count[px] = k;
        px_time[px] = 0;
    endfunction

    function automatic bit fits_cw(int px, int p[3]);
        int n, i, c, e;
        bit ok;
        n = used_of(px);
        for (i = 0; i < n; i++) begin
            e = px * MAX_CODEWORDS + i;
            ok = 1;
            for (c = 0; c < 3; c++)
                if (!(int'(rng_min[e][c]) - mlo <= p[c] && p[c] <= int'(rng_max[e][c]) + mhi))
                    ok = 0;
            if (ok) return 1;
        end
        return 0;
    endfunction

    function automatic int unsigned step_phase(int unsigned ph, int unsigned per);
        return ph + 1 >= per ? 0 : ph + 1;
    endfunction

    function automatic t_pix_out predict_pixel(t_pix_in d);
        int px;
        int p[3];
        int unsigned ui, cp;
        bit lrn, full, fg;
        t_pix_out r;
        px = pos < MAX_PIXELS ? pos : 0;
        ui = upd_int != 0 ? upd_int : 1;
        cp = clr_per != 0 ? clr_per : 1;
        p[0] = d.y;
        p[1] = d.cr;
        p[2] = d.cb;
        lrn = (longint'(frames) + 1) < longint'(learn_lim);
        full = 0;
        fg = 0;
        // learn, then clear, then test
        if (lrn || upd_ph >= ui - 1) full = learn_cw(px, p);
        if (!lrn) begin
            if (clr_ph >= cp - 1) clear_cw(px);
            fg = !fits_cw(px, p);
        end
        if (d.end_of_frame) begin
            if (frames != 32'hFFFF_FFFF) frames++;
            upd_ph = step_phase(upd_ph, ui);
            clr_ph = step_phase(clr_ph, cp);
            pos = 0;
        end else begin
            pos = px + 1 >= MAX_PIXELS ? 0 : px + 1;
        end
        r.foreground = fg;
        r.learning = lrn;
        r.codebook_full = full;
        r.frame_end = d.end_of_frame;
        return r;
    endfunction

    task automatic report(string what, logic exp_v, logic got_v);
        $display("mismatch at %0t: %s expected %0b got %0b", $realtime, what, exp_v, got_v);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pix_out exp_r;
        if (!i_rst_n) begin
            upd_int = RST_UPDATE_INTERVAL;
            learn_lim = RST_LEARN_FRAMES;
            clr_per = RST_CLEAR_PERIOD;
            bnd[0] = RST_BOUND_Y;
            bnd[1] = RST_BOUND_CR;
            bnd[2] = RST_BOUND_CB;
            mlo = $signed(RST_MARGIN_LOW);
            mhi = $signed(RST_MARGIN_HIGH);
            frames = 0;
            pos = 0;
            upd_ph = 0;
            clr_ph = 0;
            for (int k = 0; k < MAX_PIXELS; k++) begin
                cw_count[k] = 0;
                px_time[k] = 0;
            end
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UPDATE_INTERVAL: upd_int = i_cfg_data;
                    CFG_LEARN_FRAMES:    learn_lim = i_cfg_data[7:0];
                    CFG_CLEAR_PERIOD:    clr_per = i_cfg_data;
                    CFG_BOUND_Y:         bnd[0] = i_cfg_data[7:0];
                    CFG_BOUND_CR:        bnd[1] = i_cfg_data[7:0];
                    CFG_BOUND_CB:        bnd[2] = i_cfg_data[7:0];
                    CFG_MARGIN_LOW:      mlo = $signed(i_cfg_data[8:0]);
                    CFG_MARGIN_HIGH:     mhi = $signed(i_cfg_data[8:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_q.insert(expected_q.size(), predict_pixel(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result beat, valid", 1'b0, 1'b1);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out_data.foreground !== exp_r.foreground)
                        report("foreground", exp_r.foreground, i_out_data.foreground);
                    if (i_out_data.learning !== exp_r.learning)
                        report("learning", exp_r.learning, i_out_data.learning);
                    if (i_out_data.codebook_full !== exp_r.codebook_full)
                        report("codebook_full", exp_r.codebook_full, i_out_data.codebook_full);
                    if (i_out_data.frame_end !== exp_r.frame_end)
                        report("frame_end", exp_r.frame_end, i_out_data.frame_end);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- sim/tb_codebook_background_subtraction.sv -----
`timescale 1ns / 1ps
// tb_codebook_background_subtraction: stimulus and verdict for the codebook subtractor
// depends on cbs_pkg, codebook_background_subtraction and cbs_checker
module tb_codebook_background_subtraction;
    import cbs_pkg::*;

    // a small pixel store keeps the clearing pass after reset short and lets a long
    // frame wrap the pixel position
    localparam int NPIX   = 64;
    localparam int NCODE  = DEF_MAX_CODEWORDS;
    localparam int TBITS  = DEF_TIME_BITS;
    localparam int LIMIT  = 3000000;
    localparam int HOLD   = 600;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_pix_in               in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_pix_out              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    // idling percentages for the current phase, read by the sender and the receiver
    int                    send_pct;
    int                    recv_pct;
    // request for a long receiver hold-off, taken up by the receiver process
    bit                    hold_go;
    int                    hold_left;
    int                    cycles;

    // per-position background levels for the random frames
    int                    bg[NPIX][3];

    codebook_background_subtraction #(
        .MAX_PIXELS   (NPIX),
        .MAX_CODEWORDS(NCODE),
        .TIME_BITS    (TBITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    cbs_checker #(
        .MAX_PIXELS   (NPIX),
        .MAX_CODEWORDS(NCODE),
        .TIME_BITS    (TBITS)
    ) i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on the whole run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls per phase, plus a long hold-off on request
    initial begin
        hold_go = 0;
        hold_left = 0;
    end
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_left = HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
        end
    end

    // register write, one beat, taken when ready is seen at an edge
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits of the narrow registers carry junk
    function automatic logic [15:0] junk8(int val);
        return (16'($urandom) & 16'hFF00) | 16'(val & 8'hFF);
    endfunction

    function automatic logic [15:0] junk9(int val);
        return (16'($urandom) & 16'hFE00) | 16'(val & 9'h1FF);
    endfunction

    task automatic write_all(int ui, int lf, int cp, int by, int bcr, int bcb, int ml, int mh);
        cfg_write(CFG_UPDATE_INTERVAL, 16'(ui));
        cfg_write(CFG_LEARN_FRAMES, junk8(lf));
        cfg_write(CFG_CLEAR_PERIOD, 16'(cp));
        cfg_write(CFG_BOUND_Y, junk8(by));
        cfg_write(CFG_BOUND_CR, junk8(bcr));
        cfg_write(CFG_BOUND_CB, junk8(bcb));
        cfg_write(CFG_MARGIN_LOW, junk9(ml));
        cfg_write(CFG_MARGIN_HIGH, junk9(mh));
    endtask

    // one pixel beat; valid is only lowered when a gap is wanted, so a back-to-back
    // beat keeps valid high across the edge
    task automatic send_pix(int y, int cr, int cb, bit eof);
        int gap;
        gap = (send_pct > 0 && $urandom_range(99) < send_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{y: y[7:0], cr: cr[7:0], cb: cb[7:0], end_of_frame: eof};
        do @(posedge i_clk); while (!in_ready);
    endtask

    // stop offering and wait until every predicted beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int sat8(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int pick(int a, int b, int c, int lo, int hi);
        case ($urandom_range(3))
            0: return a;
            1: return b;
            2: return c;
            default: return lo + int'($urandom_range(hi - lo));
        endcase
    endfunction

    // random frames: mostly background with a little noise so codewords match and age,
    // plus fresh values and outliers that fill codebooks and show up as foreground
    task automatic run_frames(int n_items, bit long_frame, bit pause_mid);
        int fs, k, c, r, pos;
        int v[3];
        bit eof;
        fs = $urandom_range(1, 6);
        pos = 0;
        for (k = 0; k < NPIX; k++)
            for (c = 0; c < 3; c++) bg[k][c] = $urandom_range(255);
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            for (c = 0; c < 3; c++) begin
                if (r < 72) v[c] = sat8(bg[pos % NPIX][c] + $urandom_range(6) - 3);
                else if (r < 88) v[c] = $urandom_range(255);
                else v[c] = sat8(bg[pos % NPIX][c] + $urandom_range(120) - 60);
            end
            eof = (pos >= (long_frame && k < 80 ? NPIX + 6 : fs) - 1);
            // a few broken frames that end early
            if ($urandom_range(99) < 2) eof = 1;
            send_pix(v[0], v[1], v[2], eof);
            pos = eof ? 0 : pos + 1;
            if (pause_mid && k == n_items / 2) drain();
        end
    endtask

    initial begin
        int ph;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_pct  = 0;
        recv_pct  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short learning stretch, update and clear every few frames,
        // zero and full bounds, extreme margins
        write_all(1, 2, 3, 0, 255, 7, -255, 255);
        send_pix(0, 0, 0, 0);
        send_pix(255, 255, 255, 1);
        send_pix(0, 255, 128, 0);
        send_pix(255, 0, 1, 1);
        send_pix(0, 0, 0, 0);
        send_pix(254, 255, 255, 1);
        send_pix(128, 128, 128, 1);
        send_pix(1, 2, 3, 1);
        send_pix(200, 100, 50, 1);
        send_pix(0, 0, 0, 1);
        drain();
        // zero interval and period, narrow margins, tiny bounds
        write_all(0, 0, 0, 1, 0, 0, 255, -255);
        send_pix(10, 10, 10, 0);
        send_pix(250, 5, 5, 1);
        send_pix(11, 10, 10, 0);
        send_pix(250, 5, 6, 1);
        send_pix(255, 255, 255, 1);
        send_pix(0, 0, 0, 1);
        drain();
        // longest intervals and learning stretch: every frame learns, codebooks fill
        write_all(65535, 255, 65535, 255, 0, 255, 0, 0);
        for (int k = 0; k < 9; k++) send_pix(k * 29, 255 - k * 31, k * 7, 1);
        drain();

        // random phases over several settings, cycling through the idling patterns
        for (ph = 0; ph < 8; ph++) begin
            write_all(pick(0, 1, 65535, 1, 4), pick(0, 1, 255, 0, 12),
                      pick(0, 1, 65535, 1, 6), pick(0, 255, 10, 0, 20),
                      pick(0, 255, 5, 0, 20), pick(0, 255, 5, 0, 20),
                      pick(-255, 255, 0, -30, 30), pick(-255, 255, 0, -30, 30));
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 51; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 51; end
                default: begin send_pct = 28; recv_pct = 28; end
            endcase
            // long receiver hold-off while the sender keeps offering beats
            if (ph == 2) hold_go = 1;
            run_frames(185, ph == 5, ph == 3);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- codebook_background_subtraction.f -----
src/cbs_pkg.sv
src/cbs_ctrl.sv
src/cbs_datapath.sv
src/codebook_background_subtraction.sv
sim/cbs_checker.sv
sim/tb_codebook_background_subtraction.sv
